// File: sv/aht_pkg.sv
`timescale 1ns / 1ps

package aht_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned DelayW = 32;

  // input mode codes
  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_RAISE     = 3'd1,
    MODE_RAISE_NOW = 3'd2,
    MODE_CANCEL    = 3'd3,
    MODE_CANCEL_NOW = 3'd4,
    MODE_EMIT      = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    SLOT_IDLE     = 3'd0,
    SLOT_RISING   = 3'd1,
    SLOT_MAYRISE  = 3'd2,
    SLOT_RAISED   = 3'd3,
    SLOT_DROPPING = 3'd4
  } slot_status_e;

  typedef enum logic [1:0] {
    EV_RAISED    = 2'd0,
    EV_CANCELLED = 2'd1,
    EV_EMITTED   = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    CFG_RISE_DELAY    = 2'd0,
    CFG_MAYRISE_DELAY = 2'd1,
    CFG_DROP_DELAY    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DelayW-1:0] rise_delay;
    logic [DelayW-1:0] mayrise_delay;
    logic [DelayW-1:0] drop_delay;
  } cfg_t;

  typedef struct packed {
    slot_status_e     status;
    logic [TimeW-1:0] rise_time;
    logic [TimeW-1:0] visible_time;
    logic [TimeW-1:0] cancel_time;
  } entry_t;

  typedef struct packed {
    logic   vld;
    event_e ev;
  } notify_t;

endpackage

// File: sv/aht_slot_logic.sv
`timescale 1ns / 1ps

module aht_slot_logic (
  input  aht_pkg::mode_e          mode_i,
  input  aht_pkg::entry_t         entry_i,
  input  logic [aht_pkg::TimeW-1:0] now_i,
  input  aht_pkg::cfg_t           cfg_i,
  output aht_pkg::entry_t         entry_o,
  output aht_pkg::notify_t        notify_o
);
  import aht_pkg::*;

  slot_status_e      st;
  logic [TimeW-1:0]  cmp_time;
  logic              due;
  logic [TimeW-1:0]  add_a;
  logic [DelayW-1:0] add_b;
  logic [TimeW-1:0]  sum;
  logic              pending;

  assign st      = entry_i.status;
  assign pending = (st == SLOT_RISING) || (st == SLOT_MAYRISE);

  // one shared comparator: scan of a may-rise or dropping slot looks at cancel time
  assign cmp_time = ((mode_i == MODE_TICK) && (st != SLOT_RISING)) ?
                    entry_i.cancel_time : entry_i.visible_time;
  assign due = (cmp_time <= now_i);

  // one shared adder; for a raise add_a is the creation time
  always_comb begin
    if (mode_i == MODE_CANCEL) begin
      add_a = (st == SLOT_RISING) ? now_i : entry_i.rise_time;
      add_b = (st == SLOT_RISING) ? cfg_i.mayrise_delay : cfg_i.drop_delay;
    end else begin
      add_a = pending ? entry_i.rise_time : now_i;
      add_b = cfg_i.rise_delay;
    end
  end

  assign sum = add_a + TimeW'(add_b);

  always_comb begin
    entry_o  = entry_i;
    notify_o = '{vld: 1'b0, ev: EV_RAISED};
    unique case (mode_i)
      MODE_RAISE, MODE_RAISE_NOW: begin
        priority if (st == SLOT_RAISED) begin
          entry_o = entry_i;
        end else if (st == SLOT_DROPPING) begin
          entry_o.status = SLOT_RAISED;
        end else begin
          entry_o.rise_time = add_a;
          if (mode_i == MODE_RAISE_NOW) begin
            entry_o.status = SLOT_RAISED;
            notify_o       = '{vld: 1'b1, ev: EV_RAISED};
          end else if (st == SLOT_RISING) begin
            entry_o.status = SLOT_RISING;
          end else if ((st == SLOT_MAYRISE) && due) begin
            entry_o.status = SLOT_RAISED;
            notify_o       = '{vld: 1'b1, ev: EV_RAISED};
          end else begin
            entry_o.visible_time = sum;
            entry_o.status       = SLOT_RISING;
          end
        end
      end
      MODE_CANCEL: begin
        if (st == SLOT_RISING) begin
          entry_o.status      = SLOT_MAYRISE;
          entry_o.cancel_time = sum;
        end else if (st == SLOT_RAISED) begin
          entry_o.status      = SLOT_DROPPING;
          entry_o.cancel_time = sum;
        end
      end
      MODE_CANCEL_NOW: begin
        if (pending) begin
          entry_o.status = SLOT_IDLE;
        end else if ((st == SLOT_RAISED) || (st == SLOT_DROPPING)) begin
          entry_o.status = SLOT_IDLE;
          notify_o       = '{vld: 1'b1, ev: EV_CANCELLED};
        end
      end
      MODE_EMIT: begin
        notify_o = '{vld: 1'b1, ev: EV_EMITTED};
      end
      MODE_TICK: begin
        if (due) begin
          if (st == SLOT_RISING) begin
            entry_o.status = SLOT_RAISED;
            notify_o       = '{vld: 1'b1, ev: EV_RAISED};
          end else if (st == SLOT_MAYRISE) begin
            entry_o.status = SLOT_IDLE;
          end else if (st == SLOT_DROPPING) begin
            entry_o.status = SLOT_IDLE;
            notify_o       = '{vld: 1'b1, ev: EV_CANCELLED};
          end
        end
      end
      default: begin
        entry_o = entry_i;
      end
    endcase
  end

endmodule

// File: sv/alert_hysteresis_table.sv
`timescale 1ns / 1ps
// request (raise, cancel, emit): one read of the slot memory at start and one write-back
//   in S_REQ; its notification strobe is registered from S_REQ
// tick: one slot read per cycle through the memory port during S_SCAN, then S_FLUSH;
//   each notification is held back until the next one or S_FLUSH so the final one can carry last
// the receiver cannot stall; results strobe for one cycle each
// reset clears the time counter, delays, controller and the per-slot valid bits (all idle)
module alert_hysteresis_table #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [2:0]                 mode_i,
  input  logic [4:0]                 alert_index_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [aht_pkg::DelayW-1:0] cfg_wdata_i,
  output logic                       result_strobe_o,
  output logic [4:0]                 slot_out_o,
  output logic [1:0]                 event_res_o,
  output logic                       last_o
);
  import aht_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_REQ   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic [TimeW-1:0] now_q, now_d;
  cfg_t             cfg_q;
  logic [CW-1:0]    scan_cnt_q, scan_cnt_d;
  mode_e            mode_q, mode_d;

  entry_t           mem_q [SLOTS];
  logic [SLOTS-1:0] vld_q;
  entry_t           rd_data_q;
  logic             rd_vld_q;
  logic [AW-1:0]    rd_addr_q;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;

  entry_t           cur_entry;
  entry_t           new_entry;
  notify_t          notify;
  mode_e            op_mode;

  logic             out_vld_q, out_vld_d;
  logic [AW-1:0]    out_slot_q, out_slot_d;
  event_e           out_ev_q, out_ev_d;
  logic             out_last_q, out_last_d;
  logic             hold_vld_q, hold_vld_d;
  logic [AW-1:0]    hold_slot_q, hold_slot_d;
  event_e           hold_ev_q, hold_ev_d;

  logic             mode_ok;
  logic             index_ok;

  assign mode_ok  = (mode_i <= MODE_EMIT);
  assign index_ok = (32'(alert_index_i) < 32'(SLOTS));

  // a slot never written reads as idle
  always_comb begin
    cur_entry = rd_data_q;
    if (!rd_vld_q) begin
      cur_entry.status = SLOT_IDLE;
    end
  end

  assign op_mode = (state_q == S_SCAN) ? MODE_TICK : mode_q;

  aht_slot_logic u_slot_logic (
    .mode_i   (op_mode),
    .entry_i  (cur_entry),
    .now_i    (now_q),
    .cfg_i    (cfg_q),
    .entry_o  (new_entry),
    .notify_o (notify)
  );

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    scan_cnt_d  = scan_cnt_q;
    mode_d      = mode_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    out_vld_d   = 1'b0;
    out_slot_d  = out_slot_q;
    out_ev_d    = out_ev_q;
    out_last_d  = out_last_q;
    hold_vld_d  = hold_vld_q;
    hold_slot_d = hold_slot_q;
    hold_ev_d   = hold_ev_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (mode_i == MODE_TICK) begin
            now_d      = now_q + TimeW'(1);
            rd_en      = 1'b1;
            rd_addr    = '0;
            scan_cnt_d = CW'(1);
            state_d    = S_SCAN;
          end else if (mode_ok && index_ok) begin
            mode_d  = mode_e'(mode_i);
            rd_en   = 1'b1;
            rd_addr = AW'(alert_index_i);
            state_d = S_REQ;
          end
        end
      end
      S_REQ: begin
        wr_en = 1'b1;
        if (notify.vld) begin
          out_vld_d  = 1'b1;
          out_slot_d = rd_addr_q;
          out_ev_d   = notify.ev;
          out_last_d = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_SCAN: begin
        wr_en = 1'b1;
        if (notify.vld) begin
          // a newer notification means the held one is not the final one
          if (hold_vld_q) begin
            out_vld_d  = 1'b1;
            out_slot_d = hold_slot_q;
            out_ev_d   = hold_ev_q;
            out_last_d = 1'b0;
          end
          hold_vld_d  = 1'b1;
          hold_slot_d = rd_addr_q;
          hold_ev_d   = notify.ev;
        end
        if (32'(scan_cnt_q) < 32'(SLOTS)) begin
          rd_en      = 1'b1;
          rd_addr    = AW'(scan_cnt_q);
          scan_cnt_d = scan_cnt_q + CW'(1);
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (hold_vld_q) begin
          out_vld_d  = 1'b1;
          out_slot_d = hold_slot_q;
          out_ev_d   = hold_ev_q;
          out_last_d = 1'b1;
        end
        hold_vld_d = 1'b0;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      now_q      <= '0;
      scan_cnt_q <= '0;
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
      vld_q      <= '0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      scan_cnt_q <= scan_cnt_d;
      out_vld_q  <= out_vld_d;
      hold_vld_q <= hold_vld_d;
      if (wr_en) begin
        vld_q[rd_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RISE_DELAY:    cfg_q.rise_delay    <= cfg_wdata_i;
        CFG_MAYRISE_DELAY: cfg_q.mayrise_delay <= cfg_wdata_i;
        CFG_DROP_DELAY:    cfg_q.drop_delay    <= cfg_wdata_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // slot memory: one read and one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (wr_en) begin
      mem_q[rd_addr_q] <= new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    out_slot_q  <= out_slot_d;
    out_ev_q    <= out_ev_d;
    out_last_q  <= out_last_d;
    hold_slot_q <= hold_slot_d;
    hold_ev_q   <= hold_ev_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign result_strobe_o = out_vld_q;
  assign slot_out_o      = 5'(out_slot_q);
  assign event_res_o     = out_ev_q;
  assign last_o          = out_last_q;

endmodule

// File: sv/aht_checker.sv
`timescale 1ns / 1ps

module aht_checker #(
  parameter int unsigned SLOTS = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [2:0] mode_i,
  input logic [4:0] alert_index_i,
  input logic       result_strobe_o,
  input logic [4:0] slot_out_o,
  input logic [1:0] event_res_o,
  input logic       last_o
);
  import aht_pkg::*;

  logic accept;
  logic in_range;

  assign accept   = start_i && !busy_o;
  assign in_range = (32'(alert_index_i) < 32'(SLOTS));

  // an emit comes back as a single final transaction for the same slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_EMIT) && in_range) |-> ##2
      (result_strobe_o && last_o && (event_res_o == EV_EMITTED) &&
       (slot_out_o == $past(alert_index_i, 2))))
    else $error("emit transaction missing or wrong");

  // a tick always starts a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_TICK)) |=> busy_o)
    else $error("tick did not start a scan");

  // non-final transactions only come out of a scan in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_o) |-> busy_o)
    else $error("non-final transaction outside a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (event_res_o != 2'd3))
    else $error("undefined event code");

endmodule

bind alert_hysteresis_table aht_checker #(.SLOTS(SLOTS)) u_aht_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .mode_i          (mode_i),
  .alert_index_i   (alert_index_i),
  .result_strobe_o (result_strobe_o),
  .slot_out_o      (slot_out_o),
  .event_res_o     (event_res_o),
  .last_o          (last_o)
);
